// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the find-and-replace block.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is asserted
`define MPR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Concurrent check that also holds during reset
`define MPR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/core/mpr_pkg.sv -----
// Package for the multi-pattern find-and-replace block: item types,
// op codes and parameter defaults. No dependencies.
`default_nettype none

package mpr_pkg;

    localparam int DEF_PATTERNS = 8;
    localparam int DEF_MAX_LEN  = 8;

    // Op codes of an input item
    localparam logic [1:0] OP_LOAD_SEARCH  = 2'd0;
    localparam logic [1:0] OP_LOAD_REPLACE = 2'd1;
    localparam logic [1:0] OP_TEXT         = 2'd2;
    localparam logic [1:0] OP_END          = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] entry;
        logic [2:0] position;
        logic [7:0] value;
        logic [3:0] entry_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       text_end;
    } t_out_item;

endpackage

`default_nettype wire

// ----- rtl/core/multi_pattern_replace.sv -----
// Multi-pattern streaming find and replace, top level.
// Depends on mpr_pkg, mpr_ram and assert_macros.svh.
//
// Usage:
// - Input channel (i_in_valid / o_in_stall, i_in): load items write one byte
//   of a search or replacement entry and its length and give no result.
//   Text items enter a lookahead window of MAX_LEN bytes; end items
//   drain the window.
// - Output channel (o_out_valid / i_out_stall, o_out): at most one result
//   byte per output item, in order; run_last marks the last result of an
//   input item, an end item with nothing left gives one empty marker.
// - Config channel (i_cfg_valid / o_cfg_ready, i_cfg_data): pattern_count,
//   always ready; the user writes it only while idle (the block does not check).
// - A text item that does not fill the window is only stored. Filling it
//   starts a resolve: compare bytes are read one at a time, pattern by
//   pattern, through the search RAM read port, then replacement bytes are
//   read one at a time through the replacement RAM, then the dropped bytes
//   are shifted out one at a time; an end item runs up to MAX_LEN - 1
//   resolves. The input is stalled meanwhile.
// - One result is held back inside so run_last can be set; a stalled output
//   register holds the sequencer only when it has a result to hand over.
// - Reset clears lengths, count, window fill and all control; the byte
//   stores need no clearing pass.
`default_nettype none

module multi_pattern_replace #(
    parameter int PATTERNS = mpr_pkg::DEF_PATTERNS,
    parameter int MAX_LEN  = mpr_pkg::DEF_MAX_LEN
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire mpr_pkg::t_in_item  i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output mpr_pkg::t_out_item      o_out,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [3:0]         i_cfg_data
);

    `include "assert_macros.svh"

    localparam int IW = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
    localparam int PW = $clog2(PATTERNS + 1);
    localparam int JW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int EW = (LW > 4) ? LW : 4;
    localparam int XW = 7;
    localparam int AW = IW + JW;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SCAN   = 9'b000000010,
        S_CMP_RD = 9'b000000100,
        S_CMP    = 9'b000001000,
        S_REP_RD = 9'b000010000,
        S_REP    = 9'b000100000,
        S_PASS   = 9'b001000000,
        S_SHIFT  = 9'b010000000,
        S_FIN    = 9'b100000000
    } t_state;

    t_state             r_state, n_state;
    logic [PW-1:0]      r_pi, n_pi;
    logic [JW-1:0]      r_j, n_j;
    logic [LW-1:0]      r_fill, n_fill;
    logic [LW-1:0]      r_drop, n_drop;
    logic               r_end, n_end;
    logic               r_pend_valid, n_pend_valid;
    logic [7:0]         r_pend, n_pend;
    logic               r_out_valid;
    mpr_pkg::t_out_item r_out;
    logic [3:0]         r_count;
    logic [7:0]         r_win [MAX_LEN];
    logic [LW-1:0]      r_slen [PATTERNS];
    logic [LW-1:0]      r_rlen [PATTERNS];

    logic               in_acc;
    logic               slot_free;
    logic               can_go;
    logic               push;
    mpr_pkg::t_out_item push_item;
    logic               load_ok;
    logic               pos_ok;
    logic [IW-1:0]      wr_entry;
    logic [LW-1:0]      elen_sat;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [7:0]         srd;
    logic [7:0]         rrd;
    logic               scan_done;
    logic [LW-1:0]      cur_slen;
    logic [LW-1:0]      cur_rlen;
    logic [LW-1:0]      j_next;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Load decode
    assign load_ok  = (XW'(i_in.entry) < XW'(PATTERNS));
    assign pos_ok   = (XW'(i_in.position) < XW'(MAX_LEN));
    assign wr_entry = IW'(i_in.entry);
    assign elen_sat = (EW'(i_in.entry_length) > EW'(MAX_LEN)) ? LW'(MAX_LEN)
                                                               : LW'(i_in.entry_length);
    assign wr_addr  = {wr_entry, JW'(i_in.position)};
    assign rd_addr  = {r_pi[IW-1:0], r_j};

    mpr_ram #(.WIDTH(8), .DEPTH(2 ** AW)) u_search_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_in.op == mpr_pkg::OP_LOAD_SEARCH) && load_ok && pos_ok),
        .i_waddr (wr_addr),
        .i_wdata (i_in.value),
        .i_raddr (rd_addr),
        .o_rdata (srd)
    );

    mpr_ram #(.WIDTH(8), .DEPTH(2 ** AW)) u_replace_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_in.op == mpr_pkg::OP_LOAD_REPLACE) && load_ok && pos_ok),
        .i_waddr (wr_addr),
        .i_wdata (i_in.value),
        .i_raddr (rd_addr),
        .o_rdata (rrd)
    );

    // Pattern under test
    assign scan_done = (XW'(r_pi) >= XW'(r_count)) || (XW'(r_pi) >= XW'(PATTERNS));
    assign cur_slen  = r_slen[r_pi[IW-1:0]];
    assign cur_rlen  = r_rlen[r_pi[IW-1:0]];
    assign j_next    = LW'(r_j) + LW'(1);

    assign slot_free = !r_out_valid || !i_out_stall;
    assign can_go    = !r_pend_valid || slot_free;

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_pi         = r_pi;
        n_j          = r_j;
        n_fill       = r_fill;
        n_drop       = r_drop;
        n_end        = r_end;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        push         = 1'b0;
        push_item    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.op == mpr_pkg::OP_TEXT) begin
                    if (r_fill < LW'(MAX_LEN)) begin
                        n_fill = r_fill + LW'(1);
                    end
                    n_end = 1'b0;
                    n_pi  = '0;
                    if (n_fill >= LW'(MAX_LEN)) begin
                        n_state = S_SCAN;
                    end
                end else if (in_acc && i_in.op == mpr_pkg::OP_END) begin
                    n_end   = 1'b1;
                    n_pi    = '0;
                    n_state = (r_fill != '0) ? S_SCAN : S_FIN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_PASS;
                end else if (cur_slen == '0 || cur_slen > r_fill) begin
                    n_pi = r_pi + PW'(1);
                end else begin
                    n_j     = '0;
                    n_state = S_CMP_RD;
                end
            end
            S_CMP_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (srd != r_win[r_j]) begin
                    n_pi    = r_pi + PW'(1);
                    n_state = S_SCAN;
                end else if (j_next == cur_slen) begin
                    n_j     = '0;
                    n_drop  = cur_slen;
                    n_state = (cur_rlen == '0) ? S_SHIFT : S_REP_RD;
                end else begin
                    n_j     = r_j + JW'(1);
                    n_state = S_CMP_RD;
                end
            end
            S_REP_RD: begin
                n_state = S_REP;
            end
            S_REP: begin
                if (can_go) begin
                    push         = r_pend_valid;
                    push_item    = '{out_byte: r_pend, has_byte: 1'b1,
                                     run_last: 1'b0, text_end: r_end};
                    n_pend_valid = 1'b1;
                    n_pend       = rrd;
                    if (j_next == cur_rlen) begin
                        n_state = S_SHIFT;
                    end else begin
                        n_j     = r_j + JW'(1);
                        n_state = S_REP_RD;
                    end
                end
            end
            S_PASS: begin
                if (can_go) begin
                    push         = r_pend_valid;
                    push_item    = '{out_byte: r_pend, has_byte: 1'b1,
                                     run_last: 1'b0, text_end: r_end};
                    n_pend_valid = 1'b1;
                    n_pend       = r_win[0];
                    n_drop       = LW'(1);
                    n_state      = S_SHIFT;
                end
            end
            S_SHIFT: begin
                n_fill = r_fill - LW'(1);
                n_drop = r_drop - LW'(1);
                if (r_drop == LW'(1)) begin
                    if (r_end && r_fill != LW'(1)) begin
                        n_pi    = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (r_pend_valid) begin
                    if (slot_free) begin
                        push         = 1'b1;
                        push_item    = '{out_byte: r_pend, has_byte: 1'b1,
                                         run_last: 1'b1, text_end: r_end};
                        n_pend_valid = 1'b0;
                        n_state      = S_IDLE;
                    end
                end else if (r_end) begin
                    if (slot_free) begin
                        push      = 1'b1;
                        push_item = '{out_byte: 8'd0, has_byte: 1'b0,
                                      run_last: 1'b1, text_end: 1'b1};
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pi         <= '0;
            r_j          <= '0;
            r_fill       <= '0;
            r_drop       <= '0;
            r_end        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_count      <= '0;
        end else begin
            r_state      <= n_state;
            r_pi         <= n_pi;
            r_j          <= n_j;
            r_fill       <= n_fill;
            r_drop       <= n_drop;
            r_end        <= n_end;
            r_pend_valid <= n_pend_valid;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_data;
            end
        end
    end

    // Entry lengths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PATTERNS; p++) begin
                r_slen[p] <= '0;
                r_rlen[p] <= '0;
            end
        end else if (in_acc && load_ok) begin
            if (i_in.op == mpr_pkg::OP_LOAD_SEARCH) begin
                r_slen[wr_entry] <= elen_sat;
            end else if (i_in.op == mpr_pkg::OP_LOAD_REPLACE) begin
                r_rlen[wr_entry] <= elen_sat;
            end
        end
    end

    // Payload: held byte, output register, lookahead window
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (push) begin
            r_out <= push_item;
        end
        if (r_state == S_SHIFT) begin
            for (int k = 0; k < MAX_LEN - 1; k++) begin
                r_win[k] <= r_win[k + 1];
            end
        end else if (in_acc && i_in.op == mpr_pkg::OP_TEXT && r_fill < LW'(MAX_LEN)) begin
            r_win[r_fill[JW-1:0]] <= i_in.value;
        end
    end

    `MPR_ASSERT(a_fill_bound, r_fill <= LW'(MAX_LEN), "window fill beyond depth")
    `MPR_ASSERT(a_shift_drop, (r_state == S_SHIFT) |-> (r_drop != '0), "shift with zero drop")
    `MPR_ASSERT(a_idle_no_pend, (r_state == S_IDLE) |-> !r_pend_valid, "held byte left at idle")
    `MPR_ASSERT(a_empty_end, (in_acc && i_in.op == mpr_pkg::OP_END && r_fill == '0) |=> (r_state == S_FIN), "empty end item skipped marker")

endmodule

`default_nettype wire

// ----- rtl/core/mpr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the search and replacement byte stores.
`default_nettype none

module mpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the multi-pattern find-and-replace block.
// Needs mpr_pkg and the multi_pattern_replace RTL; predicts every result
// from its own copy of the tables and the lookahead window.
`timescale 1ns / 1ps

module testbench;

    localparam int NPAT   = 8;
    localparam int WLEN   = 8;
    localparam int SETTLE = 400;
    localparam int LIMIT  = 1000000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    mpr_pkg::t_in_item   i_in = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    mpr_pkg::t_out_item  o_out;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [3:0]          i_cfg_data = '0;

    multi_pattern_replace dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state
    logic [7:0] search_bytes [NPAT][WLEN];
    logic [7:0] subst_bytes  [NPAT][WLEN];
    int         search_len   [NPAT];
    int         subst_len    [NPAT];
    logic [7:0] window       [WLEN];
    int         window_used;
    int         active_count;

    mpr_pkg::t_out_item  expected_bytes [$];
    mpr_pkg::t_out_item  burst [$];
    mpr_pkg::t_in_item   pending_items [$];

    // Generator bookkeeping: which store bytes hold written data
    bit         search_written [NPAT][WLEN];
    bit         subst_written  [NPAT][WLEN];
    int         budget;
    bit         calm;

    int         errors = 0;
    int         cycles = 0;
    bit         in_taken = 1'b0;
    int         gap_left = 0;
    int         stall_left = 0;

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // Resolve the head of the window, appending emitted bytes to burst
    task automatic resolve_head(bit fin);
        int used, hit, drop;
        bit ok;
        mpr_pkg::t_out_item r;
        used = (active_count > NPAT) ? NPAT : active_count;
        hit = -1;
        for (int i = 0; i < used; i++) begin
            if (hit < 0 && search_len[i] != 0 && search_len[i] <= window_used) begin
                ok = 1'b1;
                for (int j = 0; j < search_len[i]; j++)
                    if (search_bytes[i][j] != window[j]) ok = 1'b0;
                if (ok) hit = i;
            end
        end
        if (hit >= 0) begin
            for (int j = 0; j < subst_len[hit]; j++) begin
                r = '{out_byte: subst_bytes[hit][j], has_byte: 1'b1, run_last: 1'b0,
                      text_end: fin};
                burst.push_back(r);
            end
            drop = search_len[hit];
        end else begin
            r = '{out_byte: window[0], has_byte: 1'b1, run_last: 1'b0, text_end: fin};
            burst.push_back(r);
            drop = 1;
        end
        for (int j = 0; j < window_used - drop; j++) window[j] = window[j + drop];
        window_used -= drop;
    endtask

    task automatic predict_item(mpr_pkg::t_in_item it);
        int elen;
        mpr_pkg::t_out_item r;
        elen = (it.entry_length > WLEN) ? WLEN : int'(it.entry_length);
        burst = {};
        case (it.op)
            mpr_pkg::OP_LOAD_SEARCH: begin
                search_bytes[it.entry][it.position] = it.value;
                search_len[it.entry] = elen;
            end
            mpr_pkg::OP_LOAD_REPLACE: begin
                subst_bytes[it.entry][it.position] = it.value;
                subst_len[it.entry] = elen;
            end
            mpr_pkg::OP_TEXT: begin
                if (window_used < WLEN) window[window_used++] = it.value;
                if (window_used >= WLEN) resolve_head(1'b0);
                if (burst.size() > 0) burst[burst.size() - 1].run_last = 1'b1;
            end
            default: begin
                while (window_used > 0) resolve_head(1'b1);
                if (burst.size() == 0) begin
                    r = '{out_byte: 8'd0, has_byte: 1'b0, run_last: 1'b1, text_end: 1'b1};
                    burst.push_back(r);
                end else begin
                    burst[burst.size() - 1].run_last = 1'b1;
                end
            end
        endcase
        foreach (burst[k]) expected_bytes.push_back(burst[k]);
    endtask

    // Stimulus helpers
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(99) < 85) return 8'h61 + 8'($urandom_range(2));
        return 8'($urandom);
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    task automatic push_item(logic [1:0] op, int e, int p, logic [7:0] v, int l);
        mpr_pkg::t_in_item it;
        it = '{op: op, entry: 3'(e), position: 3'(p), value: v, entry_length: 4'(l)};
        pending_items.push_back(it);
        budget--;
    endtask

    // Load a whole entry, byte by byte, so no unwritten byte is ever compared
    task automatic load_entry(logic [1:0] op, int e, int len);
        int lf, p;
        lf = (len == WLEN && $urandom_range(1)) ? $urandom_range(15, 9) : len;
        if (len == 0) begin
            p = $urandom_range(WLEN - 1);
            if (op == mpr_pkg::OP_LOAD_SEARCH) search_written[e][p] = 1'b1;
            else subst_written[e][p] = 1'b1;
            push_item(op, e, p, pick_byte(), 0);
        end
        for (int i = 0; i < len; i++) begin
            if (op == mpr_pkg::OP_LOAD_SEARCH) search_written[e][i] = 1'b1;
            else subst_written[e][i] = 1'b1;
            push_item(op, e, i, pick_byte(), lf);
        end
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 0;
        if (r < 80) return $urandom_range(3, 1);
        if (r < 90) return WLEN;
        return $urandom_range(WLEN - 1, 4);
    endfunction

    task automatic reload_random_entry();
        load_entry(mpr_pkg::OP_LOAD_SEARCH, $urandom_range(NPAT - 1), pick_len());
        load_entry(mpr_pkg::OP_LOAD_REPLACE, $urandom_range(NPAT - 1), $urandom_range(WLEN));
    endtask

    // Lone load with a random length, kept only where the bytes are written
    task automatic noise_load();
        logic [1:0] op;
        int e, p, l, lc;
        bit ok;
        op = $urandom_range(1) ? mpr_pkg::OP_LOAD_SEARCH : mpr_pkg::OP_LOAD_REPLACE;
        e = $urandom_range(NPAT - 1);
        p = $urandom_range(WLEN - 1);
        l = $urandom_range(15);
        if (op == mpr_pkg::OP_LOAD_SEARCH) search_written[e][p] = 1'b1;
        else subst_written[e][p] = 1'b1;
        lc = (l > WLEN) ? WLEN : l;
        ok = 1'b1;
        for (int i = 0; i < lc; i++)
            if (!(op == mpr_pkg::OP_LOAD_SEARCH ? search_written[e][i] : subst_written[e][i]))
                ok = 1'b0;
        push_item(op, e, p, 8'($urandom), ok ? l : 0);
    endtask

    task automatic text_run(int n);
        for (int i = 0; i < n; i++) push_item(mpr_pkg::OP_TEXT, 0, 0, pick_byte(), 0);
        push_item(mpr_pkg::OP_END, $urandom_range(7), $urandom_range(7), 8'($urandom),
                  $urandom_range(15));
    endtask

    task automatic random_phase(int n);
        int r;
        budget = n;
        while (budget > 0) begin
            r = $urandom_range(99);
            if (r < 70) text_run(($urandom_range(9) == 0) ? 20 : $urandom_range(12));
            else if (r < 85) reload_random_entry();
            else noise_load();
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || i_in_valid || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_count(logic [3:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        active_count = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Sequence of phases
    initial begin
        logic [3:0] counts [6];
        counts = '{4'd8, 4'd0, 4'd3, 4'd15, 4'd1, 4'd5};
        for (int i = 0; i < NPAT; i++) begin
            search_len[i] = 0;
            subst_len[i] = 0;
        end
        window_used = 0;
        active_count = 0;
        calm = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 6; ph++) begin
            write_count(counts[ph]);
            calm = (ph == 2);
            if (ph == 0) begin
                // Empty drain, then lowest index wins over a shorter pattern with an empty replacement
                push_item(mpr_pkg::OP_END, 0, 0, 8'h00, 0);
                push_item(mpr_pkg::OP_LOAD_SEARCH, 0, 0, 8'h61, 2);
                push_item(mpr_pkg::OP_LOAD_SEARCH, 0, 1, 8'h62, 2);
                push_item(mpr_pkg::OP_LOAD_REPLACE, 0, 0, 8'h58, 1);
                push_item(mpr_pkg::OP_LOAD_SEARCH, 1, 0, 8'h61, 1);
                push_item(mpr_pkg::OP_LOAD_REPLACE, 1, 0, 8'hff, 0);
                foreach (counts[k])
                    push_item(mpr_pkg::OP_TEXT, 0, 0, (k % 2) ? 8'h62 : 8'h61, 0);
                push_item(mpr_pkg::OP_TEXT, 0, 0, 8'h63, 0);
                push_item(mpr_pkg::OP_TEXT, 0, 0, 8'h61, 0);
                push_item(mpr_pkg::OP_TEXT, 0, 0, 8'h62, 0);
                push_item(mpr_pkg::OP_END, 7, 7, 8'hff, 15);
                // Long pattern with saturated length, long replacement
                for (int i = 0; i < WLEN; i++) begin
                    search_written[7][i] = 1'b1;
                    subst_written[7][i] = 1'b1;
                    push_item(mpr_pkg::OP_LOAD_SEARCH, 7, i, 8'h61, 15);
                end
                for (int i = 2; i < NPAT - 1; i++) begin
                    load_entry(mpr_pkg::OP_LOAD_SEARCH, i, pick_len());
                    load_entry(mpr_pkg::OP_LOAD_REPLACE, i, $urandom_range(WLEN));
                end
                load_entry(mpr_pkg::OP_LOAD_REPLACE, 7, WLEN);
            end
            random_phase(20);
            wait_idle();
        end

        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // Input acceptance and prediction
    always @(posedge i_clk) begin
        in_taken <= i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) predict_item(i_in);
    end

    // Input driver
    always @(negedge i_clk) begin
        if (i_in_valid && !in_taken) begin
            // hold the stalled item
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            i_in_valid <= 1'b0;
        end else if (i_rst_n && pending_items.size() > 0) begin
            i_in <= pending_items.pop_front();
            i_in_valid <= 1'b1;
            gap_left <= pick_gap();
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Output stall driver
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            stall_left <= pick_gap();
            i_out_stall <= 1'b0;
        end
    end

    // Result checker and run limit
    always @(posedge i_clk) begin
        mpr_pkg::t_out_item want;
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bytes.size() == 0) begin
                report("unexpected item", int'(o_out), 0);
            end else begin
                want = expected_bytes.pop_front();
                if (o_out.out_byte != want.out_byte)
                    report("out_byte", o_out.out_byte, want.out_byte);
                if (o_out.has_byte != want.has_byte)
                    report("has_byte", o_out.has_byte, want.has_byte);
                if (o_out.run_last != want.run_last)
                    report("run_last", o_out.run_last, want.run_last);
                if (o_out.text_end != want.text_end)
                    report("text_end", o_out.text_end, want.text_end);
            end
        end
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/mpr_pkg.sv
rtl/core/mpr_ram.sv
rtl/core/multi_pattern_replace.sv
tb/testbench.sv
